>>> hdl/ghfr_pkg.sv
package ghfr_pkg;

  // Byte values seen on the link.
  localparam logic [7:0] AtSign    = 8'h40;
  localparam logic [7:0] CrByte    = 8'h0D;
  localparam logic [7:0] LfByte    = 8'h0A;
  localparam logic [7:0] PhaseNone = 8'hFF;

  // Ident characters.
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChH = 8'h48;
  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChW = 8'h57;
  localparam logic [7:0] ChY = 8'h59;
  localparam logic [7:0] Chd = 8'h64;
  localparam logic [7:0] Chj = 8'h6A;

  // Frame body storage.
  localparam int unsigned BodyDepth = 6;
  localparam int unsigned BodyIdxW  = 3;
  localparam logic [3:0]  CountMax  = 4'd15;

  // Reset values.
  localparam logic [7:0]  LnavVnavReset = 8'd4;
  localparam logic [7:0]  LpvReset      = 8'd5;
  localparam logic [15:0] SbasReset     = 16'h0001;

  // Configuration register indexes.
  localparam logic CfgLnavVnav = 1'b0;
  localparam logic CfgLpv      = 1'b1;

  typedef enum logic [1:0] {
    KindByte     = 2'd0,
    KindHostSent = 2'd1,
    KindSbasSent = 2'd2,
    KindNone     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StNone    = 3'd0,
    StApplied = 3'd1,
    StBadSum  = 3'd2,
    StIgnored = 3'd3,
    StUnknown = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    HuntFirst  = 2'd0,
    HuntSecond = 2'd1,
    InFrame    = 2'd2
  } hunt_e;

  typedef struct packed {
    logic [7:0] lnav_vnav_phase_code;
    logic [7:0] lpv_phase_code;
  } cfg_t;

  typedef struct packed {
    status_e     frame_status;
    logic [7:0]  phase_now;
    logic        glideslope_on;
    logic [15:0] horiz_alert_limit;
    logic [15:0] vert_alert_limit;
    logic [15:0] sbas_choice;
    logic        hostid_pending;
    logic        sbas_pending;
  } result_t;

endpackage

>>> hdl/ghfr_core.sv
module ghfr_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        rx_byte_i,
  input  ghfr_pkg::cfg_t    cfg_i,
  output ghfr_pkg::result_t result_o
);

  ghfr_pkg::hunt_e hunt_q, hunt_d;
  logic        cr_q, cr_d;
  logic [3:0]  count_q, count_d, count_n;
  logic [7:0]  body_q [ghfr_pkg::BodyDepth];
  logic [7:0]  body_n [ghfr_pkg::BodyDepth];
  logic [7:0]  phase_q, phase_d;
  logic        gs_q, gs_d;
  logic [15:0] hal_q, hal_d;
  logic [15:0] val_q, val_d;
  logic [15:0] sbas_q, sbas_d;
  logic        hostid_q, hostid_d;
  logic        sbas_req_q, sbas_req_d;

  logic        is_byte;
  logic        frame_byte;
  logic        done;
  logic        store;
  ghfr_pkg::status_e status;

  assign is_byte    = fire_i && (ghfr_pkg::kind_e'(kind_i) == ghfr_pkg::KindByte);
  assign frame_byte = is_byte && (hunt_q == ghfr_pkg::InFrame);
  assign done       = frame_byte && (rx_byte_i == ghfr_pkg::LfByte) && cr_q;
  assign store      = frame_byte && (count_q < 4'(ghfr_pkg::BodyDepth));
  assign count_n    = (count_q == ghfr_pkg::CountMax) ? count_q : count_q + 4'd1;

  // Body as it stands once the current byte is stored.
  always_comb begin
    for (int i = 0; i < ghfr_pkg::BodyDepth; i++) begin
      body_n[i] = (count_q == 4'(i)) ? rx_byte_i : body_q[i];
    end
  end

  // True when the first n body bytes XOR to body byte n and that byte arrived.
  function automatic logic sum_ok(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [7:0] b4, input logic [7:0] b5,
                                  input logic [3:0] cnt, input logic [2:0] n);
    logic [7:0] x;
    logic [7:0] chk;
    x = b0 ^ b1;
    chk = b2;
    if (n >= 3'd3) begin
      x = x ^ b2;
      chk = b3;
    end
    if (n >= 3'd4) begin
      x = x ^ b3;
      chk = b4;
    end
    if (n >= 3'd5) begin
      x = x ^ b4;
      chk = b5;
    end
    return (cnt >= 4'({1'b0, n} + 4'd1)) && (x == chk);
  endfunction

  // Hunt state sequence.
  always_comb begin
    hunt_d = hunt_q;
    if (is_byte) begin
      unique case (hunt_q)
        ghfr_pkg::HuntFirst: begin
          if (rx_byte_i == ghfr_pkg::AtSign) hunt_d = ghfr_pkg::HuntSecond;
        end
        ghfr_pkg::HuntSecond: begin
          hunt_d = (rx_byte_i == ghfr_pkg::AtSign) ? ghfr_pkg::InFrame
                                                    : ghfr_pkg::HuntFirst;
        end
        ghfr_pkg::InFrame: begin
          if (done) hunt_d = ghfr_pkg::HuntFirst;
        end
        default: hunt_d = ghfr_pkg::HuntFirst;
      endcase
    end
  end

  // Framer counters, frame decode and the applied registers.
  always_comb begin
    cr_d       = cr_q;
    count_d    = count_q;
    phase_d    = phase_q;
    gs_d       = gs_q;
    hal_d      = hal_q;
    val_d      = val_q;
    sbas_d     = sbas_q;
    hostid_d   = hostid_q;
    sbas_req_d = sbas_req_q;
    status     = ghfr_pkg::StNone;

    if (frame_byte) begin
      cr_d    = (rx_byte_i == ghfr_pkg::CrByte) && !cr_q;
      count_d = done ? 4'd0 : count_n;
    end

    if (done) begin
      if (body_n[0] == ghfr_pkg::ChA && body_n[1] == ghfr_pkg::ChH) begin
        if (sum_ok(body_n[0], body_n[1], body_n[2], body_n[3], body_n[4], body_n[5],
                   count_n, 3'd3)) begin
          phase_d = body_n[2];
          gs_d    = (body_n[2] == cfg_i.lnav_vnav_phase_code) ||
                    (body_n[2] == cfg_i.lpv_phase_code);
          status  = ghfr_pkg::StApplied;
        end else begin
          status  = ghfr_pkg::StBadSum;
        end
      end else if (body_n[0] == ghfr_pkg::ChA && body_n[1] == ghfr_pkg::ChI) begin
        if (sum_ok(body_n[0], body_n[1], body_n[2], body_n[3], body_n[4], body_n[5],
                   count_n, 3'd4)) begin
          hal_d  = {body_n[2], body_n[3]};
          status = ghfr_pkg::StApplied;
        end else begin
          status = ghfr_pkg::StBadSum;
        end
      end else if (body_n[0] == ghfr_pkg::ChC && body_n[1] == ghfr_pkg::Chj) begin
        if (sum_ok(body_n[0], body_n[1], body_n[2], body_n[3], body_n[4], body_n[5],
                   count_n, 3'd2)) begin
          hostid_d = 1'b1;
          status   = ghfr_pkg::StApplied;
        end else begin
          status   = ghfr_pkg::StBadSum;
        end
      end else if (body_n[0] == ghfr_pkg::ChW && body_n[1] == ghfr_pkg::ChA) begin
        if (sum_ok(body_n[0], body_n[1], body_n[2], body_n[3], body_n[4], body_n[5],
                   count_n, 3'd5)) begin
          sbas_d     = {body_n[3], body_n[4]};
          sbas_req_d = 1'b1;
          status     = ghfr_pkg::StApplied;
        end else begin
          status     = ghfr_pkg::StBadSum;
        end
      end else if (body_n[0] == ghfr_pkg::ChW && body_n[1] == ghfr_pkg::Chd) begin
        if (sum_ok(body_n[0], body_n[1], body_n[2], body_n[3], body_n[4], body_n[5],
                   count_n, 3'd4)) begin
          val_d  = {body_n[2], body_n[3]};
          status = ghfr_pkg::StApplied;
        end else begin
          status = ghfr_pkg::StBadSum;
        end
      end else if (body_n[0] == ghfr_pkg::ChW && body_n[1] == ghfr_pkg::ChY) begin
        status = ghfr_pkg::StIgnored;
      end else begin
        status = ghfr_pkg::StUnknown;
      end
    end

    if (fire_i) begin
      case (ghfr_pkg::kind_e'(kind_i))
        ghfr_pkg::KindHostSent: hostid_d   = 1'b0;
        ghfr_pkg::KindSbasSent: sbas_req_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    result_o.frame_status      = status;
    result_o.phase_now         = phase_d;
    result_o.glideslope_on     = gs_d;
    result_o.horiz_alert_limit = hal_d;
    result_o.vert_alert_limit  = val_d;
    result_o.sbas_choice       = sbas_d;
    result_o.hostid_pending    = hostid_d;
    result_o.sbas_pending      = sbas_req_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q     <= ghfr_pkg::HuntFirst;
      cr_q       <= 1'b0;
      count_q    <= 4'd0;
      phase_q    <= ghfr_pkg::PhaseNone;
      gs_q       <= 1'b0;
      hal_q      <= 16'd0;
      val_q      <= 16'd0;
      sbas_q     <= ghfr_pkg::SbasReset;
      hostid_q   <= 1'b1;
      sbas_req_q <= 1'b0;
    end else begin
      hunt_q     <= hunt_d;
      cr_q       <= cr_d;
      count_q    <= count_d;
      phase_q    <= phase_d;
      gs_q       <= gs_d;
      hal_q      <= hal_d;
      val_q      <= val_d;
      sbas_q     <= sbas_d;
      hostid_q   <= hostid_d;
      sbas_req_q <= sbas_req_d;
    end
  end

  // Body bytes hold no reset; only entries written in this frame are read.
  always_ff @(posedge clk_i) begin
    if (store) begin
      body_q[count_q[ghfr_pkg::BodyIdxW-1:0]] <= rx_byte_i;
    end
  end

  a_done_rehunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (hunt_q == ghfr_pkg::HuntFirst) && (count_q == 4'd0) && !cr_q)
    else $error("frame end did not restart the hunt");

  a_idle_framer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hunt_q != ghfr_pkg::InFrame) |-> (count_q == 4'd0) && !cr_q)
    else $error("framer counters busy outside a frame");

  a_phase_only_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(phase_q) && $stable(hal_q) && $stable(val_q) && $stable(sbas_q))
    else $error("applied register changed without an item");

  a_status_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done |-> (status == ghfr_pkg::StNone))
    else $error("frame status without a frame end");

endmodule

>>> hdl/gps_host_frame_receiver.sv
// Host frame receiver for a GPS serial link. Each input beat carries one item:
// a received byte (kind 0) or a note that the host-id reply (kind 1) or the SBAS
// reply (kind 2) went out; kind 3 does nothing. Bytes are framed as two '@'
// signs, a body of ident, payload and checksum, and CR LF. When LF ends a frame
// the body is XOR-checked and applied: AH sets the flight phase and glideslope
// flag, AI sets HAL, Wd sets VAL, WA sets the SBAS word and raises its request,
// Cj raises the host-id request, WY is ignored. Every input beat yields exactly
// one output beat with the frame status and the register values after that
// item. The block takes one item per clock while the output is not stalled:
// an input register feeds the framer and decode logic, which write a result
// register, and both stages advance in the same cycle whenever the result
// register is empty or being taken; throughput is one item per cycle under no stall.
// The two phase codes that enable the glideslope are written on the
// configuration port (index 0 LNAV/VNAV, index 1 LPV); cfg_ready_o is always
// high, and writes are expected only while no item is in flight.
module gps_host_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  frame_status_o,
  output logic [7:0]  phase_now_o,
  output logic        glideslope_on_o,
  output logic [15:0] horiz_alert_limit_o,
  output logic [15:0] vert_alert_limit_o,
  output logic [15:0] sbas_choice_o,
  output logic        hostid_pending_o,
  output logic        sbas_pending_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic              s1_valid_q, s1_valid_d;
  logic [1:0]        s1_kind_q;
  logic [7:0]        s1_byte_q;
  logic              out_valid_q, out_valid_d;
  ghfr_pkg::result_t out_q;
  ghfr_pkg::result_t result;
  ghfr_pkg::cfg_t    cfg_q;

  logic advance;
  logic in_take;
  logic fire;

  // The pipe moves when the result register is free or its beat is taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && advance;

  assign s1_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q.lnav_vnav_phase_code <= ghfr_pkg::LnavVnavReset;
      cfg_q.lpv_phase_code       <= ghfr_pkg::LpvReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          ghfr_pkg::CfgLnavVnav: cfg_q.lnav_vnav_phase_code <= cfg_data_i;
          ghfr_pkg::CfgLpv:      cfg_q.lpv_phase_code       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q <= kind_i;
      s1_byte_q <= rx_byte_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  ghfr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .kind_i    (s1_kind_q),
    .rx_byte_i (s1_byte_q),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  assign out_valid_o         = out_valid_q;
  assign frame_status_o      = out_q.frame_status;
  assign phase_now_o         = out_q.phase_now;
  assign glideslope_on_o     = out_q.glideslope_on;
  assign horiz_alert_limit_o = out_q.horiz_alert_limit;
  assign vert_alert_limit_o  = out_q.vert_alert_limit;
  assign sbas_choice_o       = out_q.sbas_choice;
  assign hostid_pending_o    = out_q.hostid_pending;
  assign sbas_pending_o      = out_q.sbas_pending;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with nothing blocking");

  a_item_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("item in the input register was not moved on");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_q))
    else $error("stalled result was overwritten or dropped");

endmodule
